// ===== src/bss_pkg.sv =====
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types and codes of the bounded stack with search: request opcodes,
// result status codes and the controller states.
// ----------------------------------------------------------------------------
package bss_pkg;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_SEARCH = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_READ   = 2'd1,
    S_SEARCH = 2'd2
  } state_t;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CAP_W  = 7;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned FILL_W = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

endpackage

// ===== src/bss_ram.sv =====
// ----------------------------------------------------------------------------
// bss_ram
// Entry store of the stack: one write port and one read port, with the read
// data registered and valid in the cycle after the address.
// ----------------------------------------------------------------------------
module bss_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [AW-1:0]                  waddr,
  input  logic [bss_pkg::WORD_W-1:0]     wdata,
  input  logic [AW-1:0]                  raddr,
  output logic [bss_pkg::WORD_W-1:0]     rdata
);

  logic [bss_pkg::WORD_W-1:0] mem [DEPTH];
  logic [bss_pkg::WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/bounded_stack_with_search.sv =====
// ----------------------------------------------------------------------------
// bounded_stack_with_search
// Bounded LIFO stack of 32-bit words held in a synchronous memory, with push,
// pop, peek, clear and a top-down search for a key.
//
//   Channel   Ports                                        Handshake
//   request   in_op, in_value                              start & !busy
//   result    out_status, out_data, out_position,          out_strobe, one
//             out_fill_count                               cycle, no stall
//   config    cfg_wdata                                    cfg_we
//
// Push, clear, unused opcodes and failed requests give their result in the
// cycle after the request. Pop and peek read the top entry in S_READ and
// register it as their result. Search reads one entry per cycle through the
// memory read port, from the top down, and stops at a match or at the bottom.
// Busy is high while a pop, peek or search is in flight. Reset is synchronous
// and empties the stack at once; the memory itself is not cleared.
// ----------------------------------------------------------------------------
module bounded_stack_with_search #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [2:0]                          in_op,
  input  logic signed [bss_pkg::WORD_W-1:0]   in_value,
  output logic                                out_strobe,
  output logic [1:0]                          out_status,
  output logic signed [bss_pkg::WORD_W-1:0]   out_data,
  output logic [bss_pkg::POS_W-1:0]           out_position,
  output logic [bss_pkg::FILL_W-1:0]          out_fill_count,
  input  logic                                cfg_we,
  input  logic [bss_pkg::CAP_W-1:0]           cfg_wdata
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW = (CW > bss_pkg::CAP_W) ? CW : bss_pkg::CAP_W;
  localparam int unsigned PW = (AW > bss_pkg::POS_W) ? AW : bss_pkg::POS_W;
  localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

  bss_pkg::state_t                state_r, state_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [bss_pkg::CAP_W-1:0]      capacity_r;
  logic                           is_pop_r, is_pop_nxt;
  logic [bss_pkg::WORD_W-1:0]     key_r, key_nxt;
  logic [AW-1:0]                  idx_r, idx_nxt;
  logic                           out_strobe_r, out_strobe_nxt;
  bss_pkg::status_t               out_status_r, out_status_nxt;
  logic [bss_pkg::WORD_W-1:0]     out_data_r, out_data_nxt;
  logic [bss_pkg::POS_W-1:0]      out_position_r, out_position_nxt;
  logic [bss_pkg::FILL_W-1:0]     out_fill_r, out_fill_nxt;

  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic [AW-1:0]                  mem_raddr;
  logic [bss_pkg::WORD_W-1:0]     mem_rdata;

  logic [CW-1:0]                  count_m1;
  logic [LW-1:0]                  count_ext;
  logic [LW-1:0]                  cap_ext;
  logic [LW-1:0]                  limit;
  logic                           full;
  logic                           empty;

  function automatic logic [bss_pkg::FILL_W-1:0] to_fill(input logic [CW-1:0] c);
    logic [LW-1:0] ext;
    ext = LW'(c);
    return ext[bss_pkg::FILL_W-1:0];
  endfunction

  function automatic logic [bss_pkg::POS_W-1:0] to_pos(input logic [AW-1:0] a);
    logic [PW-1:0] ext;
    ext = PW'(a);
    return ext[bss_pkg::POS_W-1:0];
  endfunction

  bss_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_value),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign count_m1  = count_r - CW'(1);
  assign count_ext = LW'(count_r);
  assign cap_ext   = LW'(capacity_r);
  assign limit     = (cap_ext > DEPTH_L) ? DEPTH_L : cap_ext;
  assign full      = (count_ext >= limit);
  assign empty     = (count_r == '0);
  assign mem_waddr = count_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= bss_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bss_pkg::S_IDLE;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_pop_r       <= is_pop_nxt;
    key_r          <= key_nxt;
    idx_r          <= idx_nxt;
    out_status_r   <= out_status_nxt;
    out_data_r     <= out_data_nxt;
    out_position_r <= out_position_nxt;
    out_fill_r     <= out_fill_nxt;
  end

  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    is_pop_nxt       = is_pop_r;
    key_nxt          = key_r;
    idx_nxt          = idx_r;
    out_strobe_nxt   = 1'b0;
    out_status_nxt   = out_status_r;
    out_data_nxt     = out_data_r;
    out_position_nxt = out_position_r;
    out_fill_nxt     = out_fill_r;
    mem_we           = 1'b0;
    mem_raddr        = count_m1[AW-1:0];

    case (state_r)
      bss_pkg::S_IDLE: begin
        if (start) begin
          out_data_nxt     = '0;
          out_position_nxt = '0;
          out_status_nxt   = bss_pkg::ST_OK;
          out_fill_nxt     = to_fill(count_r);
          case (bss_pkg::op_t'(in_op))
            bss_pkg::OP_PUSH: begin
              out_strobe_nxt = 1'b1;
              if (full) begin
                out_status_nxt = bss_pkg::ST_FULL;
              end else begin
                mem_we       = 1'b1;
                count_nxt    = count_r + CW'(1);
                out_fill_nxt = to_fill(count_r + CW'(1));
              end
            end
            bss_pkg::OP_POP, bss_pkg::OP_PEEK: begin
              if (empty) begin
                out_strobe_nxt = 1'b1;
                out_status_nxt = bss_pkg::ST_EMPTY;
              end else begin
                is_pop_nxt = (bss_pkg::op_t'(in_op) == bss_pkg::OP_POP);
                state_nxt  = bss_pkg::S_READ;
              end
            end
            bss_pkg::OP_CLEAR: begin
              out_strobe_nxt = 1'b1;
              count_nxt      = '0;
              out_fill_nxt   = '0;
            end
            bss_pkg::OP_SEARCH: begin
              if (empty) begin
                out_strobe_nxt = 1'b1;
                out_status_nxt = bss_pkg::ST_NOTFOUND;
              end else begin
                key_nxt   = in_value;
                idx_nxt   = count_m1[AW-1:0];
                state_nxt = bss_pkg::S_SEARCH;
              end
            end
            default: begin
              out_strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      bss_pkg::S_READ: begin
        out_strobe_nxt = 1'b1;
        out_status_nxt = bss_pkg::ST_OK;
        out_data_nxt   = mem_rdata;
        if (is_pop_r) begin
          count_nxt    = count_m1;
          out_fill_nxt = to_fill(count_m1);
        end else begin
          out_fill_nxt = to_fill(count_r);
        end
        state_nxt = bss_pkg::S_IDLE;
      end
      bss_pkg::S_SEARCH: begin
        // The entry at idx_r is on the read data; the next one down is fetched.
        mem_raddr = idx_r - AW'(1);
        if (mem_rdata == key_r) begin
          out_strobe_nxt   = 1'b1;
          out_status_nxt   = bss_pkg::ST_OK;
          out_position_nxt = to_pos(idx_r);
          state_nxt        = bss_pkg::S_IDLE;
        end else if (idx_r == '0) begin
          out_strobe_nxt = 1'b1;
          out_status_nxt = bss_pkg::ST_NOTFOUND;
          state_nxt      = bss_pkg::S_IDLE;
        end else begin
          idx_nxt = idx_r - AW'(1);
        end
      end
      default: begin
        state_nxt = bss_pkg::S_IDLE;
      end
    endcase
  end

  assign busy           = (state_r != bss_pkg::S_IDLE);
  assign out_strobe     = out_strobe_r;
  assign out_status     = out_status_r;
  assign out_data       = out_data_r;
  assign out_position   = out_position_r;
  assign out_fill_count = out_fill_r;

endmodule
